[rtl/acis_pkg.sv]
package acis_pkg;

  // request and result items
  typedef struct packed {
    logic [1:0]  drive_index;
    logic        write_dir;
    logic [31:0] start_lba;
    logic [7:0]  sector_total;
  } in_item_t;

  typedef struct packed {
    logic       channel_sel;
    logic [3:0] reg_select;
    logic [7:0] write_data;
    logic       has_write;
    logic [2:0] status_code;
    logic       last;
  } out_item_t;

  // configuration register file as seen by the front end
  typedef struct packed {
    logic [3:0]       present_mask;
    logic [3:0]       packet_mask;
    logic [3:0]       lba_capable_mask;
    logic [3:0][31:0] drive_size;
  } cfg_t;

  // how the back end plays out one queued request
  typedef enum logic [1:0] {
    MODE_REJECT,
    MODE_LBA48,
    MODE_SHORT
  } mode_t;

  typedef struct packed {
    logic       channel_sel;
    mode_t      mode;
    logic [2:0] status_code;
    logic [7:0] dev_sel;
    logic [7:0] count;
    logic [7:0] lba_lo;
    logic [7:0] lba_mid;
    logic [7:0] lba_hi;
    logic [7:0] hob_lba_lo;
    logic [7:0] command;
  } cmd_t;

  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] CFG_PRESENT   = 3'd0;
  localparam logic [2:0] CFG_PACKET    = 3'd1;
  localparam logic [2:0] CFG_LBA_CAP   = 3'd2;
  localparam logic [2:0] CFG_SIZE0     = 3'd3;
  localparam logic [2:0] CFG_SIZE1     = 3'd4;
  localparam logic [2:0] CFG_SIZE2     = 3'd5;
  localparam logic [2:0] CFG_SIZE3     = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_RANGE      = 3'd2;
  localparam logic [2:0] ST_NOT_IMPL   = 3'd3;
  localparam logic [2:0] ST_WRITE_PROT = 3'd4;

  // logical taskfile registers
  localparam logic [3:0] REG_COUNT       = 4'd2;
  localparam logic [3:0] REG_LBA_LO      = 4'd3;
  localparam logic [3:0] REG_LBA_MID     = 4'd4;
  localparam logic [3:0] REG_LBA_HI      = 4'd5;
  localparam logic [3:0] REG_DEV_SEL     = 4'd6;
  localparam logic [3:0] REG_COMMAND     = 4'd7;
  localparam logic [3:0] REG_HOB_COUNT   = 4'd8;
  localparam logic [3:0] REG_HOB_LBA_LO  = 4'd9;
  localparam logic [3:0] REG_HOB_LBA_MID = 4'd10;
  localparam logic [3:0] REG_HOB_LBA_HI  = 4'd11;
  localparam logic [3:0] REG_CONTROL     = 4'd12;

  // register values
  localparam logic [7:0] CTRL_BASE     = 8'h03;
  localparam logic [7:0] CTRL_HOB      = 8'h83;
  localparam logic [7:0] DEV_SEL_LBA   = 8'hE0;
  localparam logic [7:0] DEV_SEL_CHS   = 8'hA0;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

  // chs geometry: divide a 28-bit lba by 63 with a reciprocal multiply
  localparam int LBA28_W   = 28;
  localparam int QUOT_W    = 23;
  localparam int RECIP_SH  = 34;
  localparam logic [28:0] RECIP_63 = 29'd272696337;
  localparam logic [5:0]  SECT_PER_TRACK = 6'd63;

  // back end step positions
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_CTRL        = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DEV_SEL     = 5'd1;
  localparam logic [STEP_W-1:0] STEP_HOB0_ON     = 5'd2;
  localparam logic [STEP_W-1:0] STEP_HOB0        = 5'd3;
  localparam logic [STEP_W-1:0] STEP_HOB0_OFF    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_HOB1_ON     = 5'd5;
  localparam logic [STEP_W-1:0] STEP_HOB1        = 5'd6;
  localparam logic [STEP_W-1:0] STEP_HOB1_OFF    = 5'd7;
  localparam logic [STEP_W-1:0] STEP_HOB2_ON     = 5'd8;
  localparam logic [STEP_W-1:0] STEP_HOB2        = 5'd9;
  localparam logic [STEP_W-1:0] STEP_HOB2_OFF    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_HOB3_ON     = 5'd11;
  localparam logic [STEP_W-1:0] STEP_HOB3        = 5'd12;
  localparam logic [STEP_W-1:0] STEP_HOB3_OFF    = 5'd13;
  localparam logic [STEP_W-1:0] STEP_COUNT       = 5'd14;
  localparam logic [STEP_W-1:0] STEP_LBA_LO      = 5'd15;
  localparam logic [STEP_W-1:0] STEP_LBA_MID     = 5'd16;
  localparam logic [STEP_W-1:0] STEP_LBA_HI      = 5'd17;
  localparam logic [STEP_W-1:0] STEP_COMMAND     = 5'd18;

endpackage

[rtl/acis_front.sv]
module acis_front (
  input  logic                clk,
  input  logic                rst_n,
  input  acis_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  acis_pkg::in_item_t  in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output acis_pkg::cmd_t      push_data
);

  logic                         s1_v_r;
  acis_pkg::in_item_t           item_r;
  logic [2:0]                   status_r;
  logic                         lba_cap_r;
  logic [acis_pkg::QUOT_W-1:0]  quot_r;

  logic        in_fire;
  logic        present;
  logic        atapi;
  logic        range_fail;
  logic [32:0] lba_end;
  logic [31:0] size_sel;
  logic [2:0]  status_nxt;
  logic [56:0] prod;

  logic [acis_pkg::LBA28_W:0] rem_raw;
  logic [acis_pkg::LBA28_W:0] q63;
  logic [acis_pkg::QUOT_W-1:0] quot_fix;
  logic [5:0]  rem_fix;
  logic [7:0]  sector;
  logic [15:0] cyl;
  logic        slave;
  logic        is_lba48;

  assign in_ready = !s1_v_r || push_ready;
  assign in_fire  = in_valid && in_ready;

  // request check, registered with the item
  always_comb begin
    present    = cfg.present_mask[in_data.drive_index];
    atapi      = cfg.packet_mask[in_data.drive_index];
    size_sel   = cfg.drive_size[in_data.drive_index];
    lba_end    = {1'b0, in_data.start_lba} + {25'd0, in_data.sector_total};
    range_fail = lba_end > {1'b0, size_sel};
    if (!present) begin
      status_nxt = acis_pkg::ST_NOT_FOUND;
    end else if (!atapi && range_fail) begin
      status_nxt = acis_pkg::ST_RANGE;
    end else if (atapi) begin
      status_nxt = in_data.write_dir ? acis_pkg::ST_WRITE_PROT : acis_pkg::ST_NOT_IMPL;
    end else begin
      status_nxt = acis_pkg::ST_OK;
    end
  end

  // quotient estimate of lba / 63
  assign prod = 57'(in_data.start_lba[acis_pkg::LBA28_W-1:0]) * 57'(acis_pkg::RECIP_63);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (push_ready) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r    <= in_data;
      status_r  <= status_nxt;
      lba_cap_r <= cfg.lba_capable_mask[in_data.drive_index];
      quot_r    <= prod[acis_pkg::RECIP_SH +: acis_pkg::QUOT_W];
    end
  end

  // remainder and one correction step
  always_comb begin
    q63     = ({6'd0, quot_r} << 6) - {6'd0, quot_r};
    rem_raw = {1'b0, item_r.start_lba[acis_pkg::LBA28_W-1:0]} - q63;
    if (rem_raw >= (acis_pkg::LBA28_W+1)'(acis_pkg::SECT_PER_TRACK)) begin
      quot_fix = quot_r + 1'b1;
      rem_fix  = 6'(rem_raw - (acis_pkg::LBA28_W+1)'(acis_pkg::SECT_PER_TRACK));
    end else begin
      quot_fix = quot_r;
      rem_fix  = rem_raw[5:0];
    end
    sector = {2'd0, rem_fix} + 8'd1;
    cyl    = quot_fix[19:4];
  end

  always_comb begin
    slave    = item_r.drive_index[0];
    is_lba48 = item_r.start_lba[31:28] != 4'd0;

    push_data             = '0;
    push_data.status_code = status_r;
    push_data.channel_sel = item_r.drive_index[1];
    push_data.count       = item_r.sector_total;
    push_data.hob_lba_lo  = item_r.start_lba[31:24];
    push_data.lba_lo      = item_r.start_lba[7:0];
    push_data.lba_mid     = item_r.start_lba[15:8];
    push_data.lba_hi      = item_r.start_lba[23:16];

    if (status_r != acis_pkg::ST_OK) begin
      push_data.mode = acis_pkg::MODE_REJECT;
    end else if (is_lba48) begin
      push_data.mode    = acis_pkg::MODE_LBA48;
      push_data.dev_sel = acis_pkg::DEV_SEL_LBA | {3'd0, slave, 4'd0};
      push_data.command = item_r.write_dir ? acis_pkg::CMD_WRITE_EXT
                                           : acis_pkg::CMD_READ_EXT;
    end else begin
      push_data.mode    = acis_pkg::MODE_SHORT;
      push_data.command = item_r.write_dir ? acis_pkg::CMD_WRITE : acis_pkg::CMD_READ;
      if (lba_cap_r) begin
        push_data.dev_sel = acis_pkg::DEV_SEL_LBA
                          | {3'd0, slave, item_r.start_lba[27:24]};
      end else begin
        push_data.dev_sel = acis_pkg::DEV_SEL_CHS | {3'd0, slave, quot_fix[3:0]};
        push_data.lba_lo  = sector;
        push_data.lba_mid = cyl[7:0];
        push_data.lba_hi  = cyl[15:8];
      end
    end
  end

  assign push_valid = s1_v_r;

endmodule

[rtl/acis_fifo.sv]
module acis_fifo #(
  parameter int DEPTH = acis_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  acis_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output acis_pkg::cmd_t  pop_data
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

  acis_pkg::cmd_t  slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW:0]     count_r;
  logic            push_fire;
  logic            pop_fire;

  assign push_ready = count_r != FULL_CNT;
  assign pop_valid  = count_r != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count past depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && !push_fire |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not drop on pop");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> pop_valid) else $error("pop from empty queue");

endmodule

[rtl/acis_back.sv]
module acis_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  output logic                 head_pop,
  input  acis_pkg::cmd_t       head,
  output logic                 out_valid,
  input  logic                 out_ready,
  output acis_pkg::out_item_t  out_data
);

  logic [acis_pkg::STEP_W-1:0] step_r;
  logic [acis_pkg::STEP_W-1:0] step_nxt;
  logic                        out_v_r;
  acis_pkg::out_item_t         out_r;
  acis_pkg::out_item_t         res;
  logic                        load;

  assign load = head_valid && (!out_v_r || out_ready);

  // result for the current step of the head request
  always_comb begin
    res             = '0;
    res.channel_sel = head.channel_sel;
    res.has_write   = 1'b1;
    res.status_code = acis_pkg::ST_OK;
    if (head.mode == acis_pkg::MODE_REJECT) begin
      res             = '0;
      res.status_code = head.status_code;
      res.last        = 1'b1;
    end else begin
      unique case (step_r)
        acis_pkg::STEP_CTRL, acis_pkg::STEP_HOB0_OFF, acis_pkg::STEP_HOB1_OFF,
        acis_pkg::STEP_HOB2_OFF, acis_pkg::STEP_HOB3_OFF: begin
          res.reg_select = acis_pkg::REG_CONTROL;
          res.write_data = acis_pkg::CTRL_BASE;
        end
        acis_pkg::STEP_HOB0_ON, acis_pkg::STEP_HOB1_ON, acis_pkg::STEP_HOB2_ON,
        acis_pkg::STEP_HOB3_ON: begin
          res.reg_select = acis_pkg::REG_CONTROL;
          res.write_data = acis_pkg::CTRL_HOB;
        end
        acis_pkg::STEP_DEV_SEL: begin
          res.reg_select = acis_pkg::REG_DEV_SEL;
          res.write_data = head.dev_sel;
        end
        acis_pkg::STEP_HOB0: begin
          res.reg_select = acis_pkg::REG_HOB_COUNT;
          res.write_data = 8'd0;
        end
        acis_pkg::STEP_HOB1: begin
          res.reg_select = acis_pkg::REG_HOB_LBA_LO;
          res.write_data = head.hob_lba_lo;
        end
        acis_pkg::STEP_HOB2: begin
          res.reg_select = acis_pkg::REG_HOB_LBA_MID;
          res.write_data = 8'd0;
        end
        acis_pkg::STEP_HOB3: begin
          res.reg_select = acis_pkg::REG_HOB_LBA_HI;
          res.write_data = 8'd0;
        end
        acis_pkg::STEP_COUNT: begin
          res.reg_select = acis_pkg::REG_COUNT;
          res.write_data = head.count;
        end
        acis_pkg::STEP_LBA_LO: begin
          res.reg_select = acis_pkg::REG_LBA_LO;
          res.write_data = head.lba_lo;
        end
        acis_pkg::STEP_LBA_MID: begin
          res.reg_select = acis_pkg::REG_LBA_MID;
          res.write_data = head.lba_mid;
        end
        acis_pkg::STEP_LBA_HI: begin
          res.reg_select = acis_pkg::REG_LBA_HI;
          res.write_data = head.lba_hi;
        end
        acis_pkg::STEP_COMMAND: begin
          res.reg_select = acis_pkg::REG_COMMAND;
          res.write_data = head.command;
          res.last       = 1'b1;
        end
        default: begin
          res.reg_select = acis_pkg::REG_COMMAND;
          res.write_data = head.command;
          res.last       = 1'b1;
        end
      endcase
    end
  end

  // short sequences skip the hob block
  always_comb begin
    if (res.last) begin
      step_nxt = acis_pkg::STEP_CTRL;
    end else if (head.mode == acis_pkg::MODE_SHORT && step_r == acis_pkg::STEP_DEV_SEL) begin
      step_nxt = acis_pkg::STEP_COUNT;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  assign head_pop = load && res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= acis_pkg::STEP_CTRL;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        step_r  <= step_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_mid_request_held: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != acis_pkg::STEP_CTRL |-> head_valid)
    else $error("request left the queue before its command write");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= acis_pkg::STEP_COMMAND) else $error("step counter out of range");

  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    load && head.mode == acis_pkg::MODE_REJECT |-> step_r == acis_pkg::STEP_CTRL && head_pop)
    else $error("rejected request not issued as one result");

endmodule

[rtl/ata_command_issue_sequencer.sv]
// path: a request passes the check stage register, the command queue, then the issue
//   output register; lba48 walks the hob block, lba28 and chs skip it, a reject is one
//   result; one result per cycle unless out_ready stalls; issue sets the sustained rate
// the check stage takes a new request every cycle while the command queue has room
// reset: synchronous active-low rst_n clears all handshake state, the queue and
//   every configuration register (drives absent, sizes zero)
module ata_command_issue_sequencer #(
  parameter int QUEUE_DEPTH = acis_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  acis_pkg::in_item_t               in_data,
  // result channel, one taskfile write or status per transfer
  output logic                             out_valid,
  input  logic                             out_ready,
  output acis_pkg::out_item_t              out_data,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [acis_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // configuration registers
  logic [3:0]  present_r;
  logic [3:0]  packet_r;
  logic [3:0]  lba_cap_r;
  logic [31:0] size0_r;
  logic [31:0] size1_r;
  logic [31:0] size2_r;
  logic [31:0] size3_r;
  logic        cfg_wr;
  acis_pkg::cfg_t cfg;

  // front to queue, queue to back
  logic           push_valid;
  logic           push_ready;
  acis_pkg::cmd_t push_data;
  logic           head_valid;
  logic           head_pop;
  acis_pkg::cmd_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register write, word index from the byte address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      packet_r  <= '0;
      lba_cap_r <= '0;
      size0_r   <= '0;
      size1_r   <= '0;
      size2_r   <= '0;
      size3_r   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        acis_pkg::CFG_PRESENT: present_r <= pwdata[3:0];
        acis_pkg::CFG_PACKET:  packet_r  <= pwdata[3:0];
        acis_pkg::CFG_LBA_CAP: lba_cap_r <= pwdata[3:0];
        acis_pkg::CFG_SIZE0:   size0_r   <= pwdata;
        acis_pkg::CFG_SIZE1:   size1_r   <= pwdata;
        acis_pkg::CFG_SIZE2:   size2_r   <= pwdata;
        acis_pkg::CFG_SIZE3:   size3_r   <= pwdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[4:2])
      acis_pkg::CFG_PRESENT: prdata = {28'd0, present_r};
      acis_pkg::CFG_PACKET:  prdata = {28'd0, packet_r};
      acis_pkg::CFG_LBA_CAP: prdata = {28'd0, lba_cap_r};
      acis_pkg::CFG_SIZE0:   prdata = size0_r;
      acis_pkg::CFG_SIZE1:   prdata = size1_r;
      acis_pkg::CFG_SIZE2:   prdata = size2_r;
      acis_pkg::CFG_SIZE3:   prdata = size3_r;
      default:               prdata = '0;
    endcase
  end

  assign cfg.present_mask     = present_r;
  assign cfg.packet_mask      = packet_r;
  assign cfg.lba_capable_mask = lba_cap_r;
  assign cfg.drive_size       = {size3_r, size2_r, size1_r, size0_r};

  // check stage: drive lookup, 33-bit range compare, chs divide by 63
  acis_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoded requests waiting for the issue stage
  acis_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  // issue stage: walks the taskfile write order, one result per transfer
  acis_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
